>>> design/dcc_pkg.sv
// Shared types, constants and helper functions of the dictionary code compressor.
`timescale 1ns / 1ps
package dcc_pkg;

	localparam int MAX_WORD_BITS   = 32;
	localparam int NUM_REGS        = 8;
	localparam int REG_IDX_BITS    = 3;
	localparam int IDX_BITS        = 3;
	localparam int POS_BITS        = 5;
	localparam int CNT_BITS        = 6;
	localparam int CODE_BITS       = 34;
	localparam int LEN_BITS        = 6;
	localparam int IN_TDATA_BITS   = 32;
	localparam int OUT_TDATA_BITS  = 40;
	localparam int FIFO_DEPTH      = 4;
	localparam int FIFO_PTR_BITS   = 2;
	localparam int FIFO_CNT_BITS   = 3;

	localparam logic [1:0] KIND_EXACT = 2'd0;
	localparam logic [1:0] KIND_TWO   = 2'd1;
	localparam logic [1:0] KIND_RAW   = 2'd2;

	localparam logic [1:0] PFX_EXACT = 2'b00;
	localparam logic [1:0] PFX_ADJ   = 2'b01;
	localparam logic [1:0] PFX_SEP   = 2'b10;
	localparam logic [1:0] PFX_RAW   = 2'b11;

	localparam logic [LEN_BITS-1:0] LEN_EXACT = 6'd5;
	localparam logic [LEN_BITS-1:0] LEN_ADJ   = 6'd10;
	localparam logic [LEN_BITS-1:0] LEN_SEP   = 6'd15;

	// classified item handed from front to back
	typedef struct packed {
		logic [MAX_WORD_BITS-1:0] word;
		logic [MAX_WORD_BITS-1:0] diff;
		logic [IDX_BITS-1:0]      idx;
		logic [1:0]               kind;
	} dcc_item_t;

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

	function automatic logic [CNT_BITS-1:0] popcount32(input logic [MAX_WORD_BITS-1:0] v);
		logic [4:0] lo;
		logic [4:0] hi;
		lo = 5'(popcount8(v[7:0])) + 5'(popcount8(v[15:8]));
		hi = 5'(popcount8(v[23:16])) + 5'(popcount8(v[31:24]));
		return CNT_BITS'(lo) + CNT_BITS'(hi);
	endfunction

endpackage

>>> design/dictionary_code_compressor_unit.sv
// Top level of the dictionary code compressor with bitmask mismatch coding.
// Usage:
//   Load the dictionary through cfg_we/cfg_index/cfg_wdata while no word is in
//   flight; entry i is written at a clock edge with cfg_we high and cfg_index i.
//   Words enter on the s_ channel, one transfer per cycle at full rate, while s_tready is high.
//   Each word produces exactly one code transfer on the m_ channel, in order.
//   From the input transfer to m_tvalid a word passes the count stage, which
//   loads at the input transfer, then the queue, then the output register.
//   Without stalls, throughput is one word per cycle; it is set by the single
//   popcount stage feeding the queue and the single output register draining it.
//   When m_tready is low the output register holds its code, the 4-entry queue
//   fills, and s_tready drops once the queue and the count stage are full;
//   either side may stall without losing or duplicating a transfer.
//   Reset clears the dictionary to zero and empties the pipeline and queue.
`timescale 1ns / 1ps
module dictionary_code_compressor_unit #(
	parameter int WORD_BITS    = 32,
	parameter int DICT_ENTRIES = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [dcc_pkg::REG_IDX_BITS-1:0]       cfg_index,
	input  logic [dcc_pkg::MAX_WORD_BITS-1:0]      cfg_wdata,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [dcc_pkg::IN_TDATA_BITS-1:0]      s_tdata,  // [31:0] word_in
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [dcc_pkg::OUT_TDATA_BITS-1:0]     m_tdata   // [33:0] code_bits, [39:34] code_length
);
	import dcc_pkg::*;

	logic [NUM_REGS-1:0][WORD_BITS-1:0] dict_q;

	logic      push;
	logic      pop;
	logic      fifo_full;
	logic      fifo_empty;
	dcc_item_t push_item;
	dcc_item_t head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_q <= '0;
		end else if (cfg_we) begin
			dict_q[cfg_index] <= cfg_wdata[WORD_BITS-1:0];
		end
	end

	dcc_front #(
		.WORD_BITS   (WORD_BITS),
		.DICT_ENTRIES(DICT_ENTRIES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.dict     (dict_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.push_item(push_item),
		.fifo_full(fifo_full)
	);

	dcc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_item(push_item),
		.full   (fifo_full),
		.pop    (pop),
		.rd_item(head_item),
		.empty  (fifo_empty)
	);

	dcc_back #(
		.WORD_BITS(WORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_item (head_item),
		.empty   (fifo_empty),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[39:34] == LEN_EXACT || m_tdata[39:34] == LEN_ADJ ||
			m_tdata[39:34] == LEN_SEP || m_tdata[39:34] == LEN_BITS'(WORD_BITS + 2)))
		else $error("illegal code length");

	a_exact_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[39:34] == LEN_EXACT |-> m_tdata[33:3] == '0)
		else $error("exact-match code carries bits above the index");

	a_raw_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[39:34] == LEN_BITS'(WORD_BITS + 2) |->
			m_tdata[WORD_BITS+1:WORD_BITS] == PFX_RAW)
		else $error("raw code without raw prefix");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full)
		else $error("queue written while full");

endmodule

>>> design/dcc_front.sv
// Front end: accepts words, counts mismatches per entry, picks the best entry.
`timescale 1ns / 1ps
module dcc_front #(
	parameter int WORD_BITS    = 32,
	parameter int DICT_ENTRIES = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic [dcc_pkg::NUM_REGS-1:0][WORD_BITS-1:0] dict,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	input  logic [dcc_pkg::IN_TDATA_BITS-1:0]           s_tdata,
	output logic                                        push,
	output dcc_pkg::dcc_item_t                          push_item,
	input  logic                                        fifo_full
);
	import dcc_pkg::*;

	logic                 valid_s1;
	logic [WORD_BITS-1:0] word_s1;
	logic [CNT_BITS-1:0]  cnt_s1 [DICT_ENTRIES];

	logic [WORD_BITS-1:0] word_in;
	logic [IDX_BITS-1:0]  best;
	logic [CNT_BITS-1:0]  best_cnt;
	logic [WORD_BITS-1:0] diff;

	assign word_in  = s_tdata[WORD_BITS-1:0];
	assign s_tready = !valid_s1 || !fifo_full;
	assign push     = valid_s1 && !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1 <= word_in;
			for (int k = 0; k < DICT_ENTRIES; k++) begin
				cnt_s1[k] <= popcount32(MAX_WORD_BITS'(word_in ^ dict[k]));
			end
		end
	end

	// lowest index wins a tie
	always_comb begin
		best     = '0;
		best_cnt = cnt_s1[0];
		for (int k = 1; k < DICT_ENTRIES; k++) begin
			if (cnt_s1[k] < best_cnt) begin
				best     = IDX_BITS'(k);
				best_cnt = cnt_s1[k];
			end
		end
	end

	assign diff = word_s1 ^ dict[best[REG_IDX_BITS-1:0]];

	always_comb begin
		push_item.word = MAX_WORD_BITS'(word_s1);
		push_item.diff = MAX_WORD_BITS'(diff);
		push_item.idx  = best;
		if (best_cnt == CNT_BITS'(0)) begin
			push_item.kind = KIND_EXACT;
		end else if (best_cnt == CNT_BITS'(2)) begin
			push_item.kind = KIND_TWO;
		end else begin
			push_item.kind = KIND_RAW;
		end
	end

endmodule

>>> design/dcc_fifo.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
module dcc_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dcc_pkg::dcc_item_t wr_item,
	output logic               full,
	input  logic               pop,
	output dcc_pkg::dcc_item_t rd_item,
	output logic               empty
);
	import dcc_pkg::*;

	dcc_item_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;

	assign full    = (count_q == FIFO_CNT_BITS'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/dcc_back.sv
// Back end: locates mismatch positions, builds the code, holds the output register.
`timescale 1ns / 1ps
module dcc_back #(
	parameter int WORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dcc_pkg::dcc_item_t                  rd_item,
	input  logic                                empty,
	output logic                                pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dcc_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);
	import dcc_pkg::*;

	logic                 valid_q;
	logic [CODE_BITS-1:0] code_q;
	logic [LEN_BITS-1:0]  len_q;

	logic [WORD_BITS-1:0] diff;
	logic [WORD_BITS-1:0] word;
	logic [POS_BITS-1:0]  hi;
	logic [POS_BITS-1:0]  lo;
	logic [POS_BITS-1:0]  pos1;
	logic [POS_BITS-1:0]  pos2;
	logic [CODE_BITS-1:0] code;
	logic [LEN_BITS-1:0]  len;

	assign diff = rd_item.diff[WORD_BITS-1:0];
	assign word = rd_item.word[WORD_BITS-1:0];
	assign pop  = !empty && (!valid_q || m_tready);

	// highest and lowest set bit of the mismatch mask
	always_comb begin
		hi = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (diff[i]) begin
				hi = POS_BITS'(i);
			end
		end
		lo = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (diff[i]) begin
				lo = POS_BITS'(i);
			end
		end
	end

	assign pos1 = POS_BITS'(WORD_BITS - 1) - hi;
	assign pos2 = POS_BITS'(WORD_BITS - 1) - lo;

	always_comb begin
		case (rd_item.kind)
			KIND_EXACT: begin
				code = CODE_BITS'({PFX_EXACT, rd_item.idx});
				len  = LEN_EXACT;
			end
			KIND_TWO: begin
				if (hi == lo + 1'b1) begin
					code = CODE_BITS'({PFX_ADJ, pos1, rd_item.idx});
					len  = LEN_ADJ;
				end else begin
					code = CODE_BITS'({PFX_SEP, pos1, pos2, rd_item.idx});
					len  = LEN_SEP;
				end
			end
			default: begin
				code = CODE_BITS'({PFX_RAW, word});
				len  = LEN_BITS'(WORD_BITS + 2);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_tready) begin
			valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			code_q <= code;
			len_q  <= len;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {len_q, code_q};

endmodule

>>> tb/testbench.sv
// Self-checking stream testbench for the dictionary code compressor unit.
`timescale 1ns / 1ps

class code_scoreboard;
	typedef struct packed {
		logic [33:0] code;
		logic [5:0]  len;
	} code_t;

	logic [31:0] entry[8];
	code_t       awaited[$];
	int          errors;

	function new();
		foreach (entry[i]) entry[i] = '0;
		errors = 0;
	endfunction

	function void set_entry(int idx, logic [31:0] value);
		entry[idx] = value;
	endfunction

	function int pending();
		return awaited.size();
	endfunction

	// pick the nearest entry, then encode the mismatch pattern
	function void note_word(logic [31:0] w);
		logic [31:0] diff;
		int          best;
		int          best_cnt;
		int          c;
		int          p1;
		int          p2;
		code_t       exp_code;
		best = 0;
		best_cnt = 33;
		for (int k = 0; k < 8; k++) begin
			c = $countones(w ^ entry[k]);
			if (c < best_cnt) begin
				best_cnt = c;
				best = k;
			end
		end
		diff = w ^ entry[best];
		p1 = -1;
		p2 = -1;
		for (int p = 0; p < 32; p++) begin
			if (diff[31 - p]) begin
				if (p1 < 0) p1 = p;
				else if (p2 < 0) p2 = p;
			end
		end
		if (best_cnt == 0) begin
			exp_code.code = 34'({dcc_pkg::PFX_EXACT, 3'(best)});
			exp_code.len = dcc_pkg::LEN_EXACT;
		end else if (best_cnt == 2 && p2 == p1 + 1) begin
			exp_code.code = 34'({dcc_pkg::PFX_ADJ, 5'(p1), 3'(best)});
			exp_code.len = dcc_pkg::LEN_ADJ;
		end else if (best_cnt == 2) begin
			exp_code.code = 34'({dcc_pkg::PFX_SEP, 5'(p1), 5'(p2), 3'(best)});
			exp_code.len = dcc_pkg::LEN_SEP;
		end else begin
			exp_code.code = {dcc_pkg::PFX_RAW, w};
			exp_code.len = 6'd34;
		end
		awaited.push_back(exp_code);
	endfunction

	function void check_code(logic [39:0] tdata);
		code_t want;
		if (awaited.size() == 0) begin
			$error("unexpected code transfer: tdata=%h", tdata);
			errors++;
			return;
		end
		want = awaited.pop_front();
		if (tdata[33:0] !== want.code) begin
			$error("code_bits: expected %h, actual %h", want.code, tdata[33:0]);
			errors++;
		end
		if (tdata[39:34] !== want.len) begin
			$error("code_length: expected %0d, actual %0d", want.len, tdata[39:34]);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES      = 6;
	localparam int RAND_WORDS  = 310;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] word_in
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [33:0] code_bits, [39:34] code_length

	code_scoreboard book;
	int             cycles;
	int             tx_pct;
	int             rx_pct;
	bit             hold_req;
	logic [31:0]    dict[8];

	dictionary_code_compressor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("dictionary_code_compressor_unit: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) book.check_code(m_tdata);
	end

	// receiver side: random stalls plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 99) < rx_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic [31:0] w);
		if ($urandom_range(0, 99) < tx_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		book.note_word(w);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (book.pending() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic load_dictionary();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_wdata <= dict[i];
			book.set_entry(i, dict[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// mostly near-hits of a dictionary entry, some noise
	function automatic logic [31:0] near_word();
		logic [31:0] e;
		int          p1;
		int          p2;
		e = dict[$urandom_range(0, 7)];
		case ($urandom_range(0, 9))
			0, 1: return e;
			2, 3: return e ^ (32'hC000_0000 >> $urandom_range(0, 30));
			4, 5: begin
				p1 = $urandom_range(0, 29);
				p2 = $urandom_range(p1 + 2, 31);
				return e ^ (32'h8000_0000 >> p1) ^ (32'h8000_0000 >> p2);
			end
			6: return e ^ (32'h8000_0000 >> $urandom_range(0, 31));
			7: return e ^ (32'h8000_0000 >> $urandom_range(0, 31))
				^ (32'h8000_0000 >> $urandom_range(0, 31))
				^ (32'h8000_0000 >> $urandom_range(0, 31));
			default: return $urandom();
		endcase
	endfunction

	initial begin
		book = new();
		cycles = 0;
		hold_req = 1'b0;
		tx_pct = 20;
		rx_pct = 20;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// dictionary all zero after reset
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);
		send_word(32'h8000_0000);
		send_word(32'hC000_0000);
		send_word(32'h0000_0003);
		send_word(32'h8000_0001);
		send_word(32'h0000_0005);
		send_word(32'h0000_000E);
		drain();

		// extreme entries, a duplicate pair to check tie order
		dict = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h1234_5678, 32'h1234_5678, 32'h8000_0001, 32'hFEDC_BA98};
		load_dictionary();
		for (int i = 0; i < 8; i++) send_word(dict[i]);
		send_word(32'hFFFF_FFFE);
		send_word(32'h3FFF_FFFF);
		send_word(32'hFFFF_FFFC);
		send_word(32'h7FFF_FFFE);
		send_word(32'hAAAA_AA55);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: foreach (dict[i]) dict[i] = 32'hFFFF_FFFF;
				1: begin
					dict[0] = $urandom();
					foreach (dict[i]) dict[i] = dict[0];
				end
				default: foreach (dict[i]) dict[i] = $urandom();
			endcase
			load_dictionary();
			tx_pct = (ph == 1 || ph == PHASES - 1) ? 0 : 10 * ph;
			rx_pct = (ph == 1 || ph == PHASES - 1) ? 0 : 50 - 10 * ph;
			for (int n = 0; n < RAND_WORDS; n++) begin
				if (ph == 2 && n == 40) hold_req = 1'b1;
				if (ph == 3 && n == 150) drain();
				send_word(near_word());
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (book.errors == 0 && book.pending() == 0)
			$display("dictionary_code_compressor_unit: match");
		else
			$display("dictionary_code_compressor_unit: mismatch");
		$finish;
	end
endmodule
